### design/seq_pkg.sv
// Shared types, codes and constants for the sorted event queue.
`default_nettype none

package seq_pkg;

  localparam int TAG_BITS        = 16;
  localparam int KEY_BITS        = 32;
  localparam int LEN_BITS        = 5;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ADDR_BITS       = 3;

  // configuration register indexes
  localparam logic REG_SORTED_MODE = 1'b0;

  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_ITER_RESET = 3'd3,
    OP_ITER_STEP  = 3'd4,
    OP_ITER_POP   = 3'd5,
    OP_PEEK_BACK  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_NO_POS = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 operation;
    logic [TAG_BITS-1:0] item_tag;
    logic [KEY_BITS-1:0] item_key;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic                has_item;
    logic [TAG_BITS-1:0] out_tag;
    logic [KEY_BITS-1:0] out_key;
    logic [LEN_BITS-1:0] queue_length;
    logic                queue_empty;
  } out_result_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  // per-cell shift control
  typedef struct packed {
    logic load_new;
    logic take_prev;
    logic take_next;
  } cell_ctl_t;

  // per-cell compare result against the pending key
  typedef struct packed {
    logic le;   // cell key <= pending key
    logic lt;   // cell key <  pending key
  } cell_flags_t;

endpackage

`default_nettype wire

### design/seq_cell.sv
// One queue slot: holds an entry, shifts with its neighbors, compares its key.
`default_nettype none

module seq_cell (
  input  wire logic                  clk,
  input  wire seq_pkg::cell_ctl_t    ctl,
  input  wire seq_pkg::entry_t       new_entry,
  input  wire seq_pkg::entry_t       prev_entry,
  input  wire seq_pkg::entry_t       next_entry,
  input  wire logic [seq_pkg::KEY_BITS-1:0] cmp_key,
  output seq_pkg::entry_t            entry,
  output seq_pkg::cell_flags_t       flags
);

  seq_pkg::entry_t      entry_r;
  seq_pkg::cell_flags_t flags_r;

  always_ff @(posedge clk) begin
    flags_r.le <= (entry_r.key <= cmp_key);
    flags_r.lt <= (entry_r.key <  cmp_key);
    priority if (ctl.load_new) begin
      entry_r <= new_entry;
    end else if (ctl.take_prev) begin
      entry_r <= prev_entry;
    end else if (ctl.take_next) begin
      entry_r <= next_entry;
    end else begin
      entry_r <= entry_r;
    end
  end

  assign entry = entry_r;
  assign flags = flags_r;

endmodule

`default_nettype wire

### design/sorted_event_queue.sv
// Top level of the sorted event queue: control, cursor, config port, cell chain.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------
//  input    | start / busy              | in_item  (seq_pkg::in_item_t)
//  result   | out_valid (1-cycle pulse) | out_result (seq_pkg::out_result_t)
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// Every transaction has a compare state, in which each cell compares its
// key with the pending key, then an execute state, in which the chain
// shifts and the result is registered. The next transaction can be taken at
// the edge that ends the execute state, so a new item is accepted while the
// last one executes. busy is high only in the compare cycle. out_valid marks
// the result for one cycle after the shift edge; the receiver cannot stall it.
// Synchronous active-low reset empties the queue, drops the cursor and
// sets sorted mode. Slot contents are not cleared: only held slots are read.
`default_nettype none

module sorted_event_queue #(
  parameter int QUEUE_DEPTH = seq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire seq_pkg::in_item_t     in_item,
  // result channel
  output logic                       out_valid,
  output seq_pkg::out_result_t       out_result,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [seq_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;  // slot index
  localparam int CW = $clog2(QUEUE_DEPTH + 1);                     // entry count
  localparam int D  = QUEUE_DEPTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  // control registers
  state_t               state_r,     state_nxt;
  logic [CW-1:0]        count_r,     count_nxt;
  logic [IW-1:0]        cur_r,       cur_nxt;
  logic                 cur_vld_r,   cur_vld_nxt;
  logic                 sorted_r,    sorted_nxt;
  logic                 out_valid_r, out_valid_nxt;
  seq_pkg::out_result_t result_r,    result_nxt;
  seq_pkg::in_item_t    item_r;

  logic                 accept;
  logic                 cfg_wr;

  // cell chain
  seq_pkg::entry_t      cell_q     [D];
  seq_pkg::cell_flags_t cell_f     [D];
  seq_pkg::cell_ctl_t   cell_c     [D];
  seq_pkg::entry_t      new_entry;

  // exec-cycle decode
  logic                 cur_ok;         // cursor holds a live position
  logic [D-1:0]         held;           // slot i < count
  logic [D-1:0]         hit;            // slots after the front with key <= new key
  logic [D-1:0]         hit_first;
  logic [D-1:0]         ins_oh;         // one-hot insert slot
  logic [D-1:0]         ins_ge;         // slots at or behind insert slot
  logic [D-1:0]         rem_ge;         // slots at or behind removed slot
  logic                 do_ins;
  logic                 do_rem;
  logic [IW-1:0]        rd_idx;
  seq_pkg::entry_t      rd_entry;
  logic                 full;
  logic [IW-1:0]        back_idx;

  assign busy   = (state_r == S_CMP);
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == seq_pkg::REG_SORTED_MODE) ? {31'd0, sorted_r} : 32'd0;

  assign new_entry = '{tag: item_r.item_tag, key: item_r.item_key};

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  genvar g;
  generate
    for (g = 0; g < D; g++) begin : g_cell
      seq_pkg::entry_t prev_e;
      seq_pkg::entry_t next_e;
      if (g == 0) begin : g_head
        assign prev_e = new_entry;
      end else begin : g_mid
        assign prev_e = cell_q[g-1];
      end
      if (g == D - 1) begin : g_tail
        assign next_e = cell_q[g];
      end else begin : g_body
        assign next_e = cell_q[g+1];
      end
      seq_cell u_cell (
        .clk        (clk),
        .ctl        (cell_c[g]),
        .new_entry  (new_entry),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .cmp_key    (item_r.item_key),
        .entry      (cell_q[g]),
        .flags      (cell_f[g])
      );
      assign cell_c[g] = '{load_new:  do_ins && ins_oh[g],
                           take_prev: do_ins && ins_ge[g] && !ins_oh[g],
                           take_next: do_rem && rem_ge[g]};
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < D; i++) begin
      held[i] = (CW'(i) < count_r);
      hit[i]  = (i != 0) && held[i] && cell_f[i].le;
    end
  end

  assign full      = (count_r == CW'(D));
  assign back_idx  = IW'(count_r - CW'(1));
  assign cur_ok    = cur_vld_r && (CW'(cur_r) < count_r);
  assign hit_first = hit & (~hit + D'(1));

  // insert slot: front when plain mode, empty, or new key beats the front;
  // else first later slot with key <= new key; else the back
  always_comb begin
    if (!sorted_r || (count_r == '0) || cell_f[0].lt) begin
      ins_oh = D'(1);
    end else if (hit != '0) begin
      ins_oh = hit_first;
    end else begin
      ins_oh = D'(1) << count_r;
    end
  end

  assign ins_ge   = ~(ins_oh - D'(1));
  assign rem_ge   = ~((D'(1) << rd_idx) - D'(1));
  assign rd_entry = cell_q[rd_idx];

  always_comb begin
    unique case (item_r.operation)
      seq_pkg::OP_POP_FRONT: rd_idx = '0;
      seq_pkg::OP_ITER_POP:  rd_idx = cur_r;
      default:               rd_idx = back_idx;
    endcase
  end

  // operation execute
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    cur_vld_nxt   = cur_vld_r;
    sorted_nxt    = sorted_r;
    out_valid_nxt = 1'b0;
    result_nxt    = result_r;
    do_ins        = 1'b0;
    do_rem        = 1'b0;

    if (cfg_wr && (paddr[2] == seq_pkg::REG_SORTED_MODE)) begin
      sorted_nxt = pwdata[0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = accept ? S_CMP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (state_r == S_EXEC) begin
      out_valid_nxt       = 1'b1;
      result_nxt          = '0;
      result_nxt.status   = seq_pkg::ST_OK;
      cur_vld_nxt         = cur_ok;   // stale cursor drops its position

      unique case (item_r.operation)
        seq_pkg::OP_ADD: begin
          if (full) begin
            result_nxt.status = seq_pkg::ST_FULL;
          end else begin
            do_ins    = 1'b1;
            count_nxt = count_r + CW'(1);
            if (cur_ok && ins_ge[cur_r]) begin
              cur_nxt = cur_r + IW'(1);
            end
          end
        end
        seq_pkg::OP_POP_FRONT,
        seq_pkg::OP_POP_BACK,
        seq_pkg::OP_PEEK_BACK: begin
          if (count_r == '0) begin
            result_nxt.status = seq_pkg::ST_EMPTY;
          end else begin
            result_nxt.has_item = 1'b1;
            result_nxt.out_tag  = rd_entry.tag;
            result_nxt.out_key  = rd_entry.key;
            if (item_r.operation != seq_pkg::OP_PEEK_BACK) begin
              do_rem    = 1'b1;
              count_nxt = count_r - CW'(1);
              if (cur_ok) begin
                if (cur_r == rd_idx) begin
                  cur_vld_nxt = 1'b0;
                end else if (cur_r > rd_idx) begin
                  cur_nxt = cur_r - IW'(1);
                end
              end
            end
          end
        end
        seq_pkg::OP_ITER_RESET: begin
          if (count_r == '0) begin
            result_nxt.status = seq_pkg::ST_EMPTY;
            cur_vld_nxt       = 1'b0;
            cur_nxt           = '0;
          end else begin
            cur_vld_nxt = 1'b1;
            cur_nxt     = back_idx;
          end
        end
        seq_pkg::OP_ITER_STEP: begin
          if (!cur_ok) begin
            result_nxt.status = seq_pkg::ST_NO_POS;
          end else if (cur_r == '0) begin
            cur_vld_nxt = 1'b0;
          end else begin
            cur_nxt = cur_r - IW'(1);
          end
        end
        seq_pkg::OP_ITER_POP: begin
          if (!cur_ok) begin
            result_nxt.status = seq_pkg::ST_NO_POS;
          end else begin
            result_nxt.has_item = 1'b1;
            result_nxt.out_tag  = rd_entry.tag;
            result_nxt.out_key  = rd_entry.key;
            do_rem              = 1'b1;
            count_nxt           = count_r - CW'(1);
            if (cur_r == '0) begin
              cur_vld_nxt = 1'b0;
            end else begin
              cur_nxt = cur_r - IW'(1);
            end
          end
        end
        default: begin
          // unused opcode: no change, plain ok result
        end
      endcase

      result_nxt.queue_length = seq_pkg::LEN_BITS'(count_nxt);
      result_nxt.queue_empty  = (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      cur_vld_r   <= 1'b0;
      sorted_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      cur_vld_r   <= cur_vld_nxt;
      sorted_r    <= sorted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    result_r <= result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

  // checks
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EXEC))
    else $error("result strobe without an execute cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(D))
    else $error("entry count beyond depth");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (CW'(cur_r) < count_r))
    else $error("cursor points past the back");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held for more than the compare cycle");

  a_single_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_ins && do_rem))
    else $error("insert and remove in the same cycle");

endmodule

`default_nettype wire

### dv/seq_checker.sv
// Checker for the sorted event queue: tracks the queue, predicts each result and compares.
module seq_checker #(
  parameter int QUEUE_DEPTH = seq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  seq_pkg::in_item_t                 in_item,
  input  logic                              out_valid,
  input  seq_pkg::out_result_t              out_result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [seq_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  input  logic [31:0]                       prdata,
  input  logic                              pready,
  output int                                fail_count,
  output int                                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import seq_pkg::*;

  localparam logic [ADDR_BITS-1:0] SORTED_MODE_ADDR = ADDR_BITS'(4 * int'(REG_SORTED_MODE));

  entry_t      slots [QUEUE_DEPTH];
  int          n_entries;
  int          cursor_idx;
  bit          cursor_on;
  bit          sorted_mode;
  out_result_t expected_results [$];
  out_result_t exp_res;
  int          errors;
  int          n_pending;

  assign fail_count  = errors;
  assign outstanding = n_pending;

  initial begin
    errors    = 0;
    n_pending = 0;
  end

  function automatic void drop_entry(int at);
    int i;
    for (i = at; i + 1 < n_entries; i++) slots[i] = slots[i + 1];
    n_entries--;
  endfunction

  // applies one command to the tracked queue and returns the result it should give
  function automatic out_result_t apply_command(in_item_t cmd);
    out_result_t r;
    int          at;
    int          i;
    r          = '0;
    r.status   = ST_OK;
    if (cursor_on && cursor_idx >= n_entries) cursor_on = 1'b0;
    case (cmd.operation)
      OP_ADD: begin
        if (n_entries >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          at = 0;
          // a tie with the front lands second, other ties go ahead of older equals
          if (sorted_mode && n_entries > 0 && slots[0].key >= cmd.item_key) begin
            at = n_entries;
            for (i = 1; i < n_entries; i++) begin
              if (cmd.item_key >= slots[i].key) begin
                at = i;
                break;
              end
            end
          end
          for (i = n_entries; i > at; i--) slots[i] = slots[i - 1];
          slots[at] = '{tag: cmd.item_tag, key: cmd.item_key};
          n_entries++;
          if (cursor_on && at <= cursor_idx) cursor_idx++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_BACK: begin
        if (n_entries == 0) begin
          r.status = ST_EMPTY;
        end else begin
          at         = (cmd.operation == OP_POP_FRONT) ? 0 : n_entries - 1;
          r.has_item = 1'b1;
          r.out_tag  = slots[at].tag;
          r.out_key  = slots[at].key;
          if (cmd.operation != OP_PEEK_BACK) begin
            if (cursor_on && cursor_idx == at) cursor_on = 1'b0;
            else if (cursor_on && cursor_idx > at) cursor_idx--;
            drop_entry(at);
          end
        end
      end
      OP_ITER_RESET: begin
        if (n_entries == 0) begin
          r.status   = ST_EMPTY;
          cursor_on  = 1'b0;
          cursor_idx = 0;
        end else begin
          cursor_on  = 1'b1;
          cursor_idx = n_entries - 1;
        end
      end
      OP_ITER_STEP: begin
        if (!cursor_on) r.status = ST_NO_POS;
        else if (cursor_idx == 0) cursor_on = 1'b0;
        else cursor_idx--;
      end
      OP_ITER_POP: begin
        if (!cursor_on) begin
          r.status = ST_NO_POS;
        end else begin
          at         = cursor_idx;
          r.has_item = 1'b1;
          r.out_tag  = slots[at].tag;
          r.out_key  = slots[at].key;
          drop_entry(at);
          if (at == 0) begin
            cursor_on  = 1'b0;
            cursor_idx = 0;
          end else begin
            cursor_idx = at - 1;
          end
        end
      end
      default: ;
    endcase
    r.queue_length = LEN_BITS'(n_entries);
    r.queue_empty  = (n_entries == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] expv, logic [63:0] gotv);
    if (gotv !== expv) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, expv, gotv);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_entries   = 0;
      cursor_idx  = 0;
      cursor_on   = 1'b0;
      sorted_mode = 1'b1;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with no command outstanding, expected none, got 0x%0h",
                   $time, out_result);
        end else begin
          exp_res = expected_results.pop_front();
          check_field("status", exp_res.status, out_result.status);
          check_field("has_item", exp_res.has_item, out_result.has_item);
          check_field("out_tag", exp_res.out_tag, out_result.out_tag);
          check_field("out_key", exp_res.out_key, out_result.out_key);
          check_field("queue_length", exp_res.queue_length, out_result.queue_length);
          check_field("queue_empty", exp_res.queue_empty, out_result.queue_empty);
        end
      end
      if (start && !busy) expected_results.push_back(apply_command(in_item));
      if (psel && penable && pready && paddr == SORTED_MODE_ADDR) begin
        if (pwrite) sorted_mode = pwdata[0];
        else check_field("sorted_mode readback", {31'b0, sorted_mode}, prdata);
      end
    end
    n_pending = expected_results.size();
  end

endmodule

### dv/tb_sorted_event_queue.sv
// Testbench top for the sorted event queue: clock, reset, stimulus and verdict.
module tb_sorted_event_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import seq_pkg::*;

  // 12 random phases of 136 commands plus the directed opening, about 1650 in all
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 136;
  localparam int RATE_BLOCK     = 34;   // commands per add-rate setting
  localparam int DRAIN_CYCLES   = 8;    // quiet cycles after the last result
  localparam int WATCHDOG_LIMIT = 2000; // cycles with no transaction at all

  localparam logic [ADDR_BITS-1:0] SORTED_MODE_ADDR = ADDR_BITS'(4 * int'(REG_SORTED_MODE));

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_result_t out_result;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [ADDR_BITS-1:0] paddr  = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          outstanding;
  int          quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_event_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  seq_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Watchdog: sampled mid-cycle, where every handshake signal is settled.
  // Any accepted command, result or config access counts as progress.
  always @(negedge clk) begin
    if ((start && !busy) || out_valid || psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_item_t command(op_t op, logic [TAG_BITS-1:0] tag,
                                       logic [KEY_BITS-1:0] key);
    in_item_t c;
    c.operation = op;
    c.item_tag  = tag;
    c.item_key  = key;
    return c;
  endfunction

  // Random command. Half the keys come from a tiny range so ties are common,
  // the rest are full-range or the extremes. Non-add commands carry random
  // tag/key too, which the block must ignore.
  function automatic in_item_t random_command(int add_pct);
    in_item_t c;
    int       pick;
    c.item_tag = TAG_BITS'($urandom);
    case ($urandom_range(0, 3))
      0: c.item_key = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: c.item_key = '0;
          1: c.item_key = '1;
          2: c.item_key = 32'd1;
          default: c.item_key = 32'hFFFF_FFFE;
        endcase
      end
      default: c.item_key = $urandom_range(0, 7);
    endcase
    if ($urandom_range(0, 99) < add_pct) begin
      c.operation = OP_ADD;
    end else begin
      pick = $urandom_range(0, 99);
      // iterator commands get the larger share so walks toward the front happen
      if (pick < 15) c.operation = OP_POP_FRONT;
      else if (pick < 30) c.operation = OP_POP_BACK;
      else if (pick < 45) c.operation = OP_ITER_RESET;
      else if (pick < 70) c.operation = OP_ITER_STEP;
      else if (pick < 90) c.operation = OP_ITER_POP;
      else c.operation = OP_PEEK_BACK;
    end
    return c;
  endfunction

  // Present one command and return at the edge that accepts it. Called at a
  // rising edge; start is driven once per time step. busy is sampled at the
  // falling edge, so acceptance never depends on event order at the edge.
  task automatic issue(in_item_t item, int idle_pct);
    bit taken;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start   <= 1'b1;
    in_item <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
  endtask

  // Two-phase APB transfer to the sorted_mode register (setup, then access),
  // after which the bus is returned to idle.
  task automatic cfg_access(bit wr, logic [31:0] data);
    bit done;
    psel    <= 1'b1;
    pwrite  <= wr;
    penable <= 1'b0;
    paddr   <= SORTED_MODE_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected result is in, then let the block settle.
  task automatic drain();
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] wdata;
    int          add_pct;
    int          idle_pct;
    bit          mode;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening, sorted mode from reset.
    // Everything on an empty queue: pops, peek, cursor with no position.
    issue(command(OP_POP_FRONT, '0, '0), 0);
    issue(command(OP_POP_BACK, '0, '0), 0);
    issue(command(OP_PEEK_BACK, '0, '0), 0);
    issue(command(OP_ITER_RESET, '0, '0), 0);
    issue(command(OP_ITER_STEP, '0, '0), 0);
    issue(command(OP_ITER_POP, '0, '0), 0);
    // Build 50 50 30: the second 50 ties the front and lands second;
    // a third 50 ties behind the front and goes ahead of the older equal.
    issue(command(OP_ADD, 16'hFFFF, 32'd50), 0);
    issue(command(OP_ADD, 16'h0000, 32'd50), 0);
    issue(command(OP_ADD, 16'h0001, 32'd30), 0);
    issue(command(OP_ADD, 16'h0002, 32'd50), 0);
    issue(command(OP_ADD, 16'h0003, 32'hFFFF_FFFF), 0);  // new front
    issue(command(OP_ADD, 16'h0004, 32'd0), 0);          // new back
    // Cursor tracking: insert ahead of it, remove at it, pop ahead of it.
    issue(command(OP_ITER_RESET, '0, '0), 0);
    issue(command(OP_ITER_STEP, '0, '0), 0);
    issue(command(OP_ADD, 16'h0005, 32'd40), 0);
    issue(command(OP_ITER_POP, '0, '0), 0);
    issue(command(OP_POP_FRONT, '0, '0), 0);
    issue(command(OP_POP_BACK, '0, '0), 0);
    issue(command(OP_PEEK_BACK, '0, '0), 0);
    // Cursor now sits on the back entry: popping it drops the cursor.
    issue(command(OP_POP_BACK, '0, '0), 0);
    issue(command(OP_ITER_STEP, '0, '0), 0);
    // Walk off the front: the last step loses the position with status ok.
    issue(command(OP_ITER_RESET, '0, '0), 0);
    issue(command(OP_ITER_STEP, '0, '0), 0);
    issue(command(OP_ITER_STEP, '0, '0), 0);
    issue(command(OP_ITER_STEP, '0, '0), 0);
    issue(command(OP_ITER_POP, '0, '0), 0);

    // Random phases. The mode only changes with the block idle; the add
    // rate swings between filling (queue-full refusals) and draining
    // (empty pops). Sender idling rotates through none, 70 and 28 percent.
    for (int p = 0; p < PHASES; p++) begin
      start <= 1'b0;
      drain();
      mode     = (p % 4 == 0) || (p % 4 == 3);
      idle_pct = (p % 3 == 1) ? 70 : (p % 3 == 2) ? 28 : 0;
      wdata    = $urandom;
      wdata[0] = mode;
      cfg_access(1'b1, wdata);
      cfg_access(1'b0, '0);
      add_pct = 50;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % RATE_BLOCK == 0) begin
          case ($urandom_range(0, 2))
            0: add_pct = 80;
            1: add_pct = 50;
            default: add_pct = 25;
          endcase
        end
        issue(random_command(add_pct), idle_pct);
      end
    end

    start <= 1'b0;
    drain();
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
